>>> sv/sap_pkg.sv
// Package for the stereo allpass phaser: widths, sine table, lane/FSM types,
// rounding and saturation helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sap_pkg;

  localparam int MaxStages  = 12;
  localparam int SineDepth  = 256;
  localparam int SampleBits = 16;
  localparam int StoreBits  = 24;
  localparam int SineIdxW   = $clog2(SineDepth);
  localparam int StageW     = $clog2(MaxStages);
  localparam int CountW     = 4;
  localparam int DiffW      = StoreBits + 1;
  localparam int FactW      = 18;
  localparam int ProdW      = DiffW + FactW;
  localparam int RndW       = ProdW - 16;
  localparam int SumW       = RndW + 1;
  localparam int AccW       = ProdW + 1;

  localparam logic [2:0] RegPhaseStep = 3'd0;
  localparam logic [2:0] RegModDepth  = 3'd1;
  localparam logic [2:0] RegFeedback  = 3'd2;
  localparam logic [2:0] RegWetMix    = 3'd3;
  localparam logic [2:0] RegStereoOn  = 3'd4;
  localparam logic [2:0] RegStageCnt  = 3'd5;

  typedef logic signed [16:0] sine_lut_t [SineDepth];

  typedef enum logic [2:0] {
    L_IDLE, L_FEED, L_PASS, L_UPD, L_MIXA, L_MIXB, L_DONE
  } lane_st_e;

  typedef enum logic [1:0] {
    T_IDLE, T_START, T_RUN
  } top_st_e;

  typedef struct packed {
    logic                         start;
    logic                         ack;
    logic signed [SampleBits-1:0] x;
    logic [15:0]                  coef;
    logic [15:0]                  fb;
    logic [15:0]                  wet;
    logic [CountW-1:0]            n;
  } lane_cmd_t;

  typedef struct packed {
    logic                         done;
    logic signed [SampleBits-1:0] y;
  } lane_rsp_t;

  function automatic sine_lut_t build_sine();
    sine_lut_t   lut;
    logic [31:0] q;
    logic [63:0] f, x, x2, r;
    for (int i = 0; i < SineDepth; i++) begin
      q  = 32'(i) << (32 - SineIdxW);
      f  = 64'((q >> 14) & 32'hFFFF);
      x  = q[30] ? 64'd65536 - f : f;
      x2 = (x * x) >> 16;
      r  = (64'd4737 * x2) >> 16;
      r  = 64'd42111 - r;
      r  = (r * x2) >> 16;
      r  = 64'd102918 - r;
      r  = (r * x) >> 16;
      if (r > 64'd65535) r = 64'd65535;
      lut[i] = q[31] ? -$signed({1'b0, r[15:0]}) : $signed({1'b0, r[15:0]});
    end
    return lut;
  endfunction

  localparam sine_lut_t SineLut = build_sine();

  function automatic logic signed [RndW-1:0] rnd16(logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] t;
    t = p + ProdW'(32768);
    return RndW'(t >>> 16);
  endfunction

  function automatic logic signed [StoreBits-1:0] sat_store(logic signed [SumW-1:0] v);
    if (v > SumW'((1 << (StoreBits - 1)) - 1))
      return StoreBits'((1 << (StoreBits - 1)) - 1);
    else if (v < -SumW'(1 << (StoreBits - 1)))
      return StoreBits'(-(1 << (StoreBits - 1)));
    else
      return v[StoreBits-1:0];
  endfunction

  function automatic logic signed [SampleBits-1:0] sat_sample(logic signed [SumW-1:0] v);
    if (v > SumW'((1 << (SampleBits - 1)) - 1))
      return SampleBits'((1 << (SampleBits - 1)) - 1);
    else if (v < -SumW'(1 << (SampleBits - 1)))
      return SampleBits'(-(1 << (SampleBits - 1)));
    else
      return v[SampleBits-1:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/sap_if.sv
// Valid/ready stream interfaces for phaser input and output frames.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface sap_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_in;
  logic signed [15:0] right_in;
  modport source (output valid, left_in, right_in, input ready);
  modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface sap_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface
`default_nettype wire

>>> sv/sap_lfo.sv
// LFO phase accumulator, sine table lookup and allpass coefficient register.
// Depends on sap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sap_lfo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [31:0] phase_step_i,
  input  wire logic [15:0] mod_depth_i,
  output logic      [15:0] coef_o
);
  import sap_pkg::*;

  logic [31:0]        phase_q;
  logic [15:0]        coef_q;
  logic signed [16:0] sine;
  logic [16:0]        half;
  logic [32:0]        prod;
  logic [15:0]        m;

  always_comb begin
    sine = SineLut[phase_q[31 -: SineIdxW]];
    half = 17'(($signed(18'sd65536) + 18'(sine)) >>> 1);
    prod = 33'(half) * 33'(mod_depth_i);
    m    = prod[31:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_q + phase_step_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      coef_q <= 16'd32768 + 16'(m >> 1);
    end
  end

  assign coef_o = coef_q;
endmodule
`default_nettype wire

>>> sv/sap_lane.sv
// One channel: allpass chain over stages with a shared multiplier, then blend.
// Depends on sap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sap_lane (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sap_pkg::lane_cmd_t cmd_i,
  output sap_pkg::lane_rsp_t      rsp_o
);
  import sap_pkg::*;

  lane_st_e state_q, state_d;

  logic signed [SampleBits-1:0] x_q, res_q;
  logic [15:0]                  coef_q, fb_q, wet_q;
  logic [CountW-1:0]            n_q;
  logic [StageW-1:0]            k_q;
  logic signed [StoreBits-1:0]  y_q, in_q;
  logic signed [StoreBits-1:0]  store_q [MaxStages];
  logic signed [AccW-1:0]       acc_q;

  logic signed [DiffW-1:0] mul_a;
  logic [16:0]             mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [StoreBits-1:0] z;
  logic signed [RndW-1:0]  r;
  logic signed [AccW-1:0]  mix;
  logic                    last;

  assign z    = store_q[k_q];
  assign last = (CountW'(k_q) == n_q - CountW'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE: if (cmd_i.start) state_d = L_FEED;
      L_FEED: state_d = L_PASS;
      L_PASS: state_d = L_UPD;
      L_UPD:  state_d = last ? L_MIXA : L_FEED;
      L_MIXA: state_d = L_MIXB;
      L_MIXB: state_d = L_DONE;
      L_DONE: if (cmd_i.ack) state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      L_FEED: begin mul_a = DiffW'(y_q); mul_b = 17'(fb_q); end
      L_PASS: begin mul_a = DiffW'(in_q) - DiffW'(z); mul_b = 17'(coef_q); end
      L_UPD:  begin mul_a = DiffW'(y_q); mul_b = 17'(coef_q); end
      L_MIXA: begin mul_a = DiffW'(x_q); mul_b = 17'd65536 - 17'(wet_q); end
      L_MIXB: begin mul_a = DiffW'(y_q); mul_b = 17'(wet_q); end
      default: ;
    endcase
    prod = ProdW'(mul_a) * $signed({1'b0, mul_b});
    r    = rnd16(prod);
    mix  = acc_q + AccW'(prod) + AccW'(32768);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      for (int i = 0; i < MaxStages; i++) store_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == L_UPD)
        store_q[k_q] <= sat_store(SumW'(in_q) - SumW'(r));
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      L_IDLE: if (cmd_i.start) begin
        x_q    <= cmd_i.x;
        coef_q <= cmd_i.coef;
        fb_q   <= cmd_i.fb;
        wet_q  <= cmd_i.wet;
        n_q    <= cmd_i.n;
        k_q    <= '0;
        y_q    <= '0;
      end
      L_FEED: in_q <= sat_store(SumW'(x_q) + SumW'(r));
      L_PASS: y_q  <= sat_store(SumW'(r) + SumW'(z));
      L_UPD:  k_q  <= k_q + StageW'(1);
      L_MIXA: acc_q <= AccW'(prod);
      L_MIXB: res_q <= sat_sample(SumW'(mix >>> 16));
      default: ;
    endcase
  end

  assign rsp_o.done = (state_q == L_DONE);
  assign rsp_o.y    = res_q;
endmodule
`default_nettype wire

>>> sv/stereo_allpass_phaser.sv
// Stereo allpass phaser top: APB registers, LFO, two lanes, output merge.
// Depends on sap_pkg, sap_if, sap_lfo, sap_lane.
// Stages in use are clamped to 2..12. A new frame is accepted only after the
// previous result is loaded into the output register. In stereo mode both lanes
// run in parallel on one shared multiplier each, one multiply per cycle per lane.
// Reset: async active low; registers to defaults, LFO phase and stores to zero.
`timescale 1ns / 1ps
`default_nettype none
module stereo_allpass_phaser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  sap_in_if.sink           in_i,
  sap_out_if.source        out_o
);
  import sap_pkg::*;

  logic [31:0]       phase_step_q;
  logic [15:0]       mod_depth_q, feedback_q, wet_mix_q;
  logic              stereo_on_q;
  logic [CountW-1:0] stage_cnt_q;
  logic [2:0]        reg_idx;
  logic              wr_en;

  top_st_e state_q, state_d;
  logic    mono_q;
  logic signed [SampleBits-1:0] xl_q, xr_q;
  logic [15:0]       coef;
  logic [CountW-1:0] n_clamp;
  logic              accept, lanes_done, load;
  logic              out_valid_q;
  logic signed [SampleBits-1:0] out_l_q, out_r_q;
  lane_cmd_t cmd_l, cmd_r;
  lane_rsp_t rsp_l, rsp_r;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= 32'd97391;
      mod_depth_q  <= 16'd32768;
      feedback_q   <= 16'd32768;
      wet_mix_q    <= 16'd32768;
      stereo_on_q  <= 1'b1;
      stage_cnt_q  <= CountW'(4);
    end else if (wr_en) begin
      unique case (reg_idx)
        RegPhaseStep: phase_step_q <= pwdata;
        RegModDepth:  mod_depth_q  <= pwdata[15:0];
        RegFeedback:  feedback_q   <= pwdata[15:0];
        RegWetMix:    wet_mix_q    <= pwdata[15:0];
        RegStereoOn:  stereo_on_q  <= pwdata[0];
        RegStageCnt:  stage_cnt_q  <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegPhaseStep: prdata = phase_step_q;
      RegModDepth:  prdata = 32'(mod_depth_q);
      RegFeedback:  prdata = 32'(feedback_q);
      RegWetMix:    prdata = 32'(wet_mix_q);
      RegStereoOn:  prdata = 32'(stereo_on_q);
      RegStageCnt:  prdata = 32'(stage_cnt_q);
      default: ;
    endcase
  end

  always_comb begin
    if (stage_cnt_q < CountW'(2))              n_clamp = CountW'(2);
    else if (stage_cnt_q > CountW'(MaxStages)) n_clamp = CountW'(MaxStages);
    else                                       n_clamp = stage_cnt_q;
  end

  assign accept     = in_i.valid & in_i.ready;
  assign lanes_done = rsp_l.done & (mono_q | rsp_r.done);
  assign load       = (state_q == T_RUN) & lanes_done & (~out_valid_q | out_o.ready);

  sap_lfo u_lfo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .phase_step_i (phase_step_q),
    .mod_depth_i  (mod_depth_q),
    .coef_o       (coef)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE:  if (in_i.valid) state_d = T_START;
      T_START: state_d = T_RUN;
      T_RUN:   if (load) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready    = (state_q == T_IDLE);
    cmd_l.start   = (state_q == T_START);
    cmd_l.ack     = load;
    cmd_l.x       = xl_q;
    cmd_l.coef    = coef;
    cmd_l.fb      = feedback_q;
    cmd_l.wet     = wet_mix_q;
    cmd_l.n       = n_clamp;
    cmd_r         = cmd_l;
    cmd_r.start   = (state_q == T_START) & ~mono_q;
    cmd_r.x       = xr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load)             out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      xl_q   <= in_i.left_in;
      xr_q   <= in_i.right_in;
      mono_q <= ~stereo_on_q;
    end
    if (load) begin
      out_l_q <= rsp_l.y;
      out_r_q <= mono_q ? '0 : rsp_r.y;
    end
  end

  sap_lane u_lane_l (.clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd_l), .rsp_o(rsp_l));
  sap_lane u_lane_r (.clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd_r), .rsp_o(rsp_r));

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = out_l_q;
  assign out_o.right_out = out_r_q;
endmodule
`default_nettype wire
